### rtl/complex_arith_unit_core_defines.svh
// Assertion macros used by the checker file.
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("complex_arith_unit_core: check failed");

// Next-cycle implication, off while reset is asserted.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("complex_arith_unit_core: check failed");

`endif

### rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

endpackage

`default_nettype wire

### rtl/complex_arith_unit_core.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fractional; Q8.8 by default). One transaction
// enters per cycle and one result leaves per cycle while the output is not
// stalled; every transaction, whatever its action, passes the products and
// sums stages, the divider setup register, the restoring divider, which
// resolves one quotient bit per stage over DATA_WIDTH + 1 stages, and the
// output register; add, subtract and multiply ride the same pipeline so results come
// out in order. Multiply floors the products by 2^FRAC_BITS; divide truncates
// toward zero. Overflowing parts saturate and raise saturated_o; a zero
// divisor raises div_zero_o and gives a zero result. The whole pipeline
// advances together and holds when the output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module complex_arith_unit_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   action_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] a_im_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_re_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      res_re_o,
  output logic signed [DATA_WIDTH-1:0]      res_im_o,
  output logic                              div_zero_o,
  output logic                              saturated_o
);

  localparam int W   = DATA_WIDTH;
  localparam int NW  = 2 * W + 1;        // numerator width, signed
  localparam int DW  = 2 * W;            // divisor width, unsigned
  localparam int QW  = W + 1;            // quotient bits resolved
  localparam int RW  = 3 * W + FRAC_BITS + 2;
  localparam int SW  = 2 * W + 7;        // sideband through the divider
  localparam int NST = W + 1;            // divider stages

  localparam logic [W-1:0]  MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MinW = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] Lim  = QW'(1) << (W - 1);

  // Advance everything unless the result register is held.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // products and sums
  logic                 f_valid, f_is_div, f_dz, f_dir_sat;
  logic signed [NW-1:0] f_num_re, f_num_im;
  logic [DW-1:0]        f_den;
  logic [W-1:0]         f_dir_re, f_dir_im;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .action_i  (action_i),
    .a_re_i    (a_re_i),
    .a_im_i    (a_im_i),
    .b_re_i    (b_re_i),
    .b_im_i    (b_im_i),
    .valid_o   (f_valid),
    .is_div_o  (f_is_div),
    .div_zero_o(f_dz),
    .num_re_o  (f_num_re),
    .num_im_o  (f_num_im),
    .den_o     (f_den),
    .dir_re_o  (f_dir_re),
    .dir_im_o  (f_dir_im),
    .dir_sat_o (f_dir_sat)
  );

  // Divider setup: take magnitudes, scale by 2^FRAC_BITS and flag any
  // quotient that cannot fit in QW bits.
  logic          neg_re, neg_im, ovf_re_d, ovf_im_d;
  logic [NW-1:0] mag_re, mag_im;
  logic [RW-1:0] x_re_d, x_im_d, den_top;

  always_comb begin
    neg_re   = f_num_re[NW-1];
    neg_im   = f_num_im[NW-1];
    mag_re   = neg_re ? NW'(-f_num_re) : NW'(f_num_re);
    mag_im   = neg_im ? NW'(-f_num_im) : NW'(f_num_im);
    x_re_d   = RW'(mag_re) << FRAC_BITS;
    x_im_d   = RW'(mag_im) << FRAC_BITS;
    den_top  = RW'(f_den) << QW;
    ovf_re_d = (x_re_d >= den_top);
    ovf_im_d = (x_im_d >= den_top);
  end

  logic          v_ch   [0:NST];
  logic [RW-1:0] rre_ch [0:NST];
  logic [RW-1:0] rim_ch [0:NST];
  logic [QW-1:0] qre_ch [0:NST];
  logic [QW-1:0] qim_ch [0:NST];
  logic [DW-1:0] den_ch [0:NST];
  logic [SW-1:0] sb_ch  [0:NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_ch[0] <= 1'b0;
    end else if (en) begin
      v_ch[0] <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rre_ch[0] <= x_re_d;
      rim_ch[0] <= x_im_d;
      qre_ch[0] <= '0;
      qim_ch[0] <= '0;
      den_ch[0] <= f_den;
      sb_ch[0]  <= {f_is_div, f_dz, f_dir_re, f_dir_im, f_dir_sat,
                    neg_re, neg_im, ovf_re_d, ovf_im_d};
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NST; k++) begin : g_div
    cau_div_stage #(
      .RW (RW),
      .DW (DW),
      .QW (QW),
      .SW (SW),
      .BIT(QW - 1 - k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_ch[k]),
      .rem_re_i(rre_ch[k]),
      .rem_im_i(rim_ch[k]),
      .quo_re_i(qre_ch[k]),
      .quo_im_i(qim_ch[k]),
      .den_i   (den_ch[k]),
      .side_i  (sb_ch[k]),
      .valid_o (v_ch[k+1]),
      .rem_re_o(rre_ch[k+1]),
      .rem_im_o(rim_ch[k+1]),
      .quo_re_o(qre_ch[k+1]),
      .quo_im_o(qim_ch[k+1]),
      .den_o   (den_ch[k+1]),
      .side_o  (sb_ch[k+1])
    );
  end

  // {clip, value} for a signed quotient
  function automatic logic [W:0] qsat(logic [QW-1:0] q, logic ovf, logic neg);
    logic [W:0]    r;
    logic [QW-1:0] nq;
    nq = -q;
    if (neg) begin
      if (ovf || q > Lim) begin
        r = {1'b1, MinW};
      end else begin
        r = {1'b0, nq[W-1:0]};
      end
    end else begin
      if (ovf || q > Lim - QW'(1)) begin
        r = {1'b1, MaxW};
      end else begin
        r = {1'b0, q[W-1:0]};
      end
    end
    return r;
  endfunction

  // Result selection: unpack the sideband that rode through the divider.
  logic          l_is_div, l_dz, l_dir_sat, l_neg_re, l_neg_im, l_ovf_re, l_ovf_im;
  logic [W-1:0]  l_dir_re, l_dir_im;
  logic [W:0]    dq_re, dq_im;
  logic [W-1:0]  res_re_d, res_im_d;
  logic          dz_d, sat_d;

  always_comb begin
    {l_is_div, l_dz, l_dir_re, l_dir_im, l_dir_sat,
     l_neg_re, l_neg_im, l_ovf_re, l_ovf_im} = sb_ch[NST];
    dq_re = qsat(qre_ch[NST], l_ovf_re, l_neg_re);
    dq_im = qsat(qim_ch[NST], l_ovf_im, l_neg_im);
    if (!l_is_div) begin
      res_re_d = l_dir_re;
      res_im_d = l_dir_im;
      dz_d     = 1'b0;
      sat_d    = l_dir_sat;
    end else if (l_dz) begin
      res_re_d = '0;
      res_im_d = '0;
      dz_d     = 1'b1;
      sat_d    = 1'b0;
    end else begin
      res_re_d = dq_re[W-1:0];
      res_im_d = dq_im[W-1:0];
      dz_d     = 1'b0;
      sat_d    = dq_re[W] | dq_im[W];
    end
  end

  // Output register: hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= v_ch[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_o    <= res_re_d;
      res_im_o    <= res_im_d;
      div_zero_o  <= dz_d;
      saturated_o <= sat_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cau_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_front #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [1:0]                     action_i,
  input  wire logic signed [DATA_WIDTH-1:0]   a_re_i,
  input  wire logic signed [DATA_WIDTH-1:0]   a_im_i,
  input  wire logic signed [DATA_WIDTH-1:0]   b_re_i,
  input  wire logic signed [DATA_WIDTH-1:0]   b_im_i,
  output logic                                valid_o,
  output logic                                is_div_o,
  output logic                                div_zero_o,
  output logic signed [2*DATA_WIDTH:0]        num_re_o,
  output logic signed [2*DATA_WIDTH:0]        num_im_o,
  output logic [2*DATA_WIDTH-1:0]             den_o,
  output logic [DATA_WIDTH-1:0]               dir_re_o,
  output logic [DATA_WIDTH-1:0]               dir_im_o,
  output logic                                dir_sat_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;

  localparam logic signed [NW-1:0] MaxV = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW-1:0] MinV = {{(NW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinW = {1'b1, {(W-1){1'b0}}};

  // {clip, value}
  function automatic logic [W:0] sat_fn(logic signed [NW-1:0] v);
    logic [W:0] r;
    if (v > MaxV) begin
      r = {1'b1, MaxW};
    end else if (v < MinV) begin
      r = {1'b1, MinW};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // products stage
  logic                 v1_q;
  cau_pkg::action_e     act_q, act_d;
  logic signed [PW-1:0] ac_q, bd_q, bc_q, ad_q, cc_q, dd_q;
  logic signed [PW-1:0] ac_d, bd_d, bc_d, ad_d, cc_d, dd_d;
  logic signed [W:0]    sre_q, sim_q, sre_d, sim_d;

  always_comb begin
    act_d = cau_pkg::action_e'(action_i);
    ac_d  = a_re_i * b_re_i;
    bd_d  = a_im_i * b_im_i;
    bc_d  = a_im_i * b_re_i;
    ad_d  = a_re_i * b_im_i;
    cc_d  = b_re_i * b_re_i;
    dd_d  = b_im_i * b_im_i;
    if (act_d == cau_pkg::ACT_SUB) begin
      sre_d = {a_re_i[W-1], a_re_i} - {b_re_i[W-1], b_re_i};
      sim_d = {a_im_i[W-1], a_im_i} - {b_im_i[W-1], b_im_i};
    end else begin
      sre_d = {a_re_i[W-1], a_re_i} + {b_re_i[W-1], b_re_i};
      sim_d = {a_im_i[W-1], a_im_i} + {b_im_i[W-1], b_im_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_q <= act_d;
      ac_q  <= ac_d;
      bd_q  <= bd_d;
      bc_q  <= bc_d;
      ad_q  <= ad_d;
      cc_q  <= cc_d;
      dd_q  <= dd_d;
      sre_q <= sre_d;
      sim_q <= sim_d;
    end
  end

  // sums stage
  logic signed [NW-1:0] acx, bdx, bcx, adx, num_re_d, num_im_d;
  logic [PW-1:0]        den_d;
  logic [W:0]           sat_re, sat_im;
  logic                 is_div_d, dz_d;

  always_comb begin
    acx = {ac_q[PW-1], ac_q};
    bdx = {bd_q[PW-1], bd_q};
    bcx = {bc_q[PW-1], bc_q};
    adx = {ad_q[PW-1], ad_q};
    is_div_d = (act_q == cau_pkg::ACT_DIV);
    if (is_div_d) begin
      num_re_d = acx + bdx;
      num_im_d = bcx - adx;
    end else begin
      num_re_d = acx - bdx;
      num_im_d = bcx + adx;
    end
    den_d = unsigned'(cc_q) + unsigned'(dd_q);
    dz_d  = is_div_d && (den_d == '0);
    if (act_q == cau_pkg::ACT_MUL) begin
      sat_re = sat_fn(num_re_d >>> FRAC_BITS);
      sat_im = sat_fn(num_im_d >>> FRAC_BITS);
    end else begin
      sat_re = sat_fn(NW'(sre_q));
      sat_im = sat_fn(NW'(sim_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      is_div_o   <= is_div_d;
      div_zero_o <= dz_d;
      num_re_o   <= num_re_d;
      num_im_o   <= num_im_d;
      den_o      <= den_d;
      dir_re_o   <= sat_re[W-1:0];
      dir_im_o   <= sat_im[W-1:0];
      dir_sat_o  <= sat_re[W] | sat_im[W];
    end
  end

endmodule

`default_nettype wire

### rtl/cau_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_div_stage #(
  parameter int RW  = 58,
  parameter int DW  = 32,
  parameter int QW  = 17,
  parameter int SW  = 39,
  parameter int BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [RW-1:0] rem_re_i,
  input  wire logic [RW-1:0] rem_im_i,
  input  wire logic [QW-1:0] quo_re_i,
  input  wire logic [QW-1:0] quo_im_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [RW-1:0]      rem_re_o,
  output logic [RW-1:0]      rem_im_o,
  output logic [QW-1:0]      quo_re_o,
  output logic [QW-1:0]      quo_im_o,
  output logic [DW-1:0]      den_o,
  output logic [SW-1:0]      side_o
);

  logic [RW-1:0] sub;
  logic [RW-1:0] rem_re_d, rem_im_d;
  logic [QW-1:0] quo_re_d, quo_im_d;

  // one restoring step per part: try den * 2^BIT
  always_comb begin
    sub      = RW'(den_i) << BIT;
    rem_re_d = rem_re_i;
    rem_im_d = rem_im_i;
    quo_re_d = quo_re_i;
    quo_im_d = quo_im_i;
    if (rem_re_i >= sub) begin
      rem_re_d      = rem_re_i - sub;
      quo_re_d[BIT] = 1'b1;
    end
    if (rem_im_i >= sub) begin
      rem_im_d      = rem_im_i - sub;
      quo_im_d[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      quo_re_o <= quo_re_d;
      quo_im_o <= quo_im_d;
      den_o    <= den_i;
      side_o   <= side_i;
    end
  end

endmodule

`default_nettype wire

### rtl/cau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arith_unit_core_defines.svh"

module cau_checker #(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [DATA_WIDTH-1:0] res_re_o,
  input wire logic [DATA_WIDTH-1:0] res_im_o,
  input wire logic                  div_zero_o,
  input wire logic                  saturated_o
);

  localparam logic [DATA_WIDTH-1:0] MaxW = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MinW = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic in_pending;
  assign in_pending = in_valid_i;

  // a zero divisor gives a clean zero result
  `CAU_ASSERT_NOW(a_div_zero_clean, out_valid_o && div_zero_o,
                  res_re_o == '0 && res_im_o == '0 && !saturated_o)
  // a clipped result shows a rail value on at least one part
  `CAU_ASSERT_NOW(a_sat_rail, out_valid_o && saturated_o,
                  res_re_o == MaxW || res_re_o == MinW ||
                  res_im_o == MaxW || res_im_o == MinW)
  // input is held back only by a blocked result
  `CAU_ASSERT_NOW(a_stall_cause, in_pending && in_stall_o,
                  out_valid_o && out_stall_i)
  // a stalled result stays put
  `CAU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(res_re_o) && $stable(res_im_o))

endmodule

bind complex_arith_unit_core cau_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .res_re_o   (res_re_o),
  .res_im_o   (res_im_o),
  .div_zero_o (div_zero_o),
  .saturated_o(saturated_o)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int W    = 16;
  localparam int FRAC = 8;
  localparam longint MAXV = (64'sd1 <<< (W - 1)) - 1;
  localparam longint MINV = -(64'sd1 <<< (W - 1));

  typedef struct {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                dz;
    logic                sat;
  } cplx_res_t;

  typedef struct {
    cau_pkg::action_e    act;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
    bit                  typed;
    cplx_res_t           res;
  } op_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = '0;
  logic signed [W-1:0] a_re_i = '0;
  logic signed [W-1:0] a_im_i = '0;
  logic signed [W-1:0] b_re_i = '0;
  logic signed [W-1:0] b_im_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [W-1:0] res_re_o;
  logic signed [W-1:0] res_im_o;
  logic                div_zero_o;
  logic                saturated_o;

  cplx_res_t pending_q[$];
  int        fail_cnt  = 0;
  int        idle_pct  = 0;
  int        stall_pct = 0;

  complex_arith_unit_core #(.DATA_WIDTH(W), .FRAC_BITS(FRAC)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .a_re_i, .a_im_i,
    .b_re_i, .b_im_i, .out_valid_o, .out_stall_i, .res_re_o, .res_im_o,
    .div_zero_o, .saturated_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [W-1:0] clamp(longint v, inout logic sat);
    if (v > MAXV) begin
      sat = 1'b1;
      return MAXV[W-1:0];
    end
    if (v < MINV) begin
      sat = 1'b1;
      return MINV[W-1:0];
    end
    return v[W-1:0];
  endfunction

  // Exact wide arithmetic; only the final parts clip.
  function automatic cplx_res_t complex_result(cau_pkg::action_e act,
                                               logic signed [W-1:0] a,
                                               logic signed [W-1:0] b,
                                               logic signed [W-1:0] c,
                                               logic signed [W-1:0] d);
    longint    ra, rb, rc, rd, re, im, den;
    cplx_res_t r;
    ra = a; rb = b; rc = c; rd = d;
    re = 0; im = 0;
    r.dz = 1'b0;
    r.sat = 1'b0;
    case (act)
      cau_pkg::ACT_ADD: begin
        re = ra + rc;
        im = rb + rd;
      end
      cau_pkg::ACT_SUB: begin
        re = ra - rc;
        im = rb - rd;
      end
      cau_pkg::ACT_MUL: begin
        re = (ra * rc - rb * rd) >>> FRAC;
        im = (rb * rc + ra * rd) >>> FRAC;
      end
      default: begin
        den = rc * rc + rd * rd;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          re = ((ra * rc + rb * rd) <<< FRAC) / den;
          im = ((rb * rc - ra * rd) <<< FRAC) / den;
        end
      end
    endcase
    r.re = clamp(re, r.sat);
    r.im = clamp(im, r.sat);
    return r;
  endfunction

  task automatic send_op(cau_pkg::action_e act, logic signed [W-1:0] a,
                         logic signed [W-1:0] b,
                         logic signed [W-1:0] c, logic signed [W-1:0] d,
                         cplx_res_t expected);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    a_re_i     <= a;
    a_im_i     <= b;
    b_re_i     <= c;
    b_im_i     <= d;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(expected);
  endtask

  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(5))
      0:       return MAXV[W-1:0];
      1:       return MINV[W-1:0];
      2:       return W'(int'($urandom_range(1023)) - 512);
      3:       return '0;
      default: return W'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cplx_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction re=%0d im=%0d", res_re_o, res_im_o);
        fail_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (res_re_o !== e.re) begin
          $error("res_re: expected %0d, got %0d", e.re, res_re_o);
          fail_cnt++;
        end
        if (res_im_o !== e.im) begin
          $error("res_im: expected %0d, got %0d", e.im, res_im_o);
          fail_cnt++;
        end
        if (div_zero_o !== e.dz) begin
          $error("div_zero: expected %0b, got %0b", e.dz, div_zero_o);
          fail_cnt++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, saturated_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    op_row_t          rows[$];
    op_row_t          row;
    cplx_res_t        e;
    int               phase_pct[4][2];
    cau_pkg::action_e act;

    phase_pct = '{'{0, 0}, '{72, 0}, '{0, 72}, '{34, 34}};

    // Typed rows carry their expected results; the others get them from complex_result.
    rows = '{
      '{cau_pkg::ACT_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1,
        '{16'sd0, 16'sd0, 1'b0, 1'b0}},
      '{cau_pkg::ACT_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1,
        '{16'sh7fff, 16'sh7fff, 1'b0, 1'b1}},
      '{cau_pkg::ACT_ADD, -16'sh8000, -16'sh8000, -16'sh8000, 16'sd0, 1,
        '{-16'sh8000, -16'sh8000, 1'b0, 1'b1}},
      '{cau_pkg::ACT_SUB, -16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 1,
        '{-16'sh8000, 16'sh7fff, 1'b0, 1'b1}},
      '{cau_pkg::ACT_SUB, 16'sd5, 16'sd7, 16'sd5, 16'sd7, 1,
        '{16'sd0, 16'sd0, 1'b0, 1'b0}},
      '{cau_pkg::ACT_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1,
        '{16'sd256, 16'sd0, 1'b0, 1'b0}},
      '{cau_pkg::ACT_DIV, 16'sd5, -16'sd9, 16'sd0, 16'sd0, 1,
        '{16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{cau_pkg::ACT_DIV, 16'sh7fff, -16'sh8000, 16'sd0, 16'sd0, 1,
        '{16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{cau_pkg::ACT_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0, 0, '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, 0,
        '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0,
        '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_MUL, 16'sd3, -16'sd5, -16'sd7, 16'sd11, 0, '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 0, '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, -16'sd300, 16'sd77, 16'sd512, -16'sd256, 0,
        '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, 16'sh7fff, 16'sh7fff, 16'sd1, 16'sd0, 0, '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, -16'sh8000, 16'sd1, 16'sd0, -16'sd1, 0, '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, 16'sd1, -16'sd1, -16'sh8000, 16'sh7fff, 0,
        '{'0, '0, '0, '0}},
      '{cau_pkg::ACT_DIV, -16'sd1, 16'sd0, 16'sd3, 16'sd0, 0, '{'0, '0, '0, '0}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      e = row.typed ? row.res
                    : complex_result(row.act, row.a_re, row.a_im, row.b_re, row.b_im);
      send_op(row.act, row.a_re, row.a_im, row.b_re, row.b_im, e);
    end

    // Walk the idle and stall phases with random transactions.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_pct[p][0];
      stall_pct = phase_pct[p][1];
      for (int n = 0; n < 125; n++) begin
        act = cau_pkg::action_e'($urandom_range(3));
        row.a_re = rand_operand();
        row.a_im = rand_operand();
        row.b_re = rand_operand();
        row.b_im = rand_operand();
        if (act == cau_pkg::ACT_DIV && $urandom_range(15) == 0) begin
          row.b_re = '0;
          row.b_im = '0;
        end
        e = complex_result(act, row.a_re, row.a_im, row.b_re, row.b_im);
        send_op(act, row.a_re, row.a_im, row.b_re, row.b_im, e);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
